// ----- hw/rtl/vpci_pkg.sv -----
// Shared types and constants for the legacy virtio PCI register block.
// Holds command and result payload structs, command codes and header offsets.
// No dependencies.
package vpci_pkg;

	// Command codes on the request channel
	localparam logic [2:0] CMD_READ  = 3'd0;
	localparam logic [2:0] CMD_WRITE = 3'd1;
	localparam logic [2:0] CMD_USED  = 3'd2;
	localparam logic [2:0] CMD_POLL  = 3'd3;
	localparam logic [2:0] CMD_RESET = 3'd4;

	// Legacy header byte offsets
	localparam logic [7:0] OFS_HOST_FEAT      = 8'd0;
	localparam logic [7:0] OFS_GUEST_FEATURES = 8'd4;
	localparam logic [7:0] OFS_QUEUE_PFN      = 8'd8;
	localparam logic [7:0] OFS_QUEUE_NUM      = 8'd12;
	localparam logic [7:0] OFS_QUEUE_SEL      = 8'd14;
	localparam logic [7:0] OFS_QUEUE_NOTIFY   = 8'd16;
	localparam logic [7:0] OFS_STATUS         = 8'd18;
	localparam logic [7:0] OFS_ISR            = 8'd19;
	localparam logic [7:0] OFS_CONFIG_VECTOR  = 8'd20;
	localparam logic [7:0] OFS_QUEUE_VECTOR   = 8'd22;

	localparam logic [15:0] NO_VECTOR   = 16'hFFFF;
	localparam logic [7:0]  STATUS_MASK = 8'hFF;
	localparam logic [63:0] ALL_ONES    = ~64'd0;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  bar;
		logic [7:0]  address;
		logic [31:0] write_data;
		logic        queue;
		logic        guest_no_interrupt;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        vec_update;
		logic        notify_valid;
		logic        notify_queue;
		logic        irq_fire;
		logic [15:0] irq_vector;
		logic        online;
	} rsp_t;

	// Decoded operation handed from controller to datapath
	typedef enum logic [2:0] {
		OP_NONE,
		OP_READ,
		OP_WRITE,
		OP_USED,
		OP_POLL,
		OP_RESET
	} op_t;

	typedef struct packed {
		logic load;   // capture request payload
		logic exec;   // execute captured command this cycle
		op_t  op;
	} dp_ctl_t;

endpackage

// ----- hw/rtl/vpci_ctrl.sv -----
// Controller for the virtio PCI register block: accepts commands, decodes
// them and sequences the datapath and the done strobe.
// Depends on vpci_pkg.
module vpci_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           command,
	output logic                 busy,
	output logic                 done,
	output vpci_pkg::dp_ctl_t    ctl
);
	import vpci_pkg::*;

	logic accept;
	op_t  op_dec;
	logic exec_s1;
	op_t  op_s1;
	logic done_q;

	// One command per cycle; nothing ever stalls the request side.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_comb begin
		unique case (command)
			CMD_READ:  op_dec = OP_READ;
			CMD_WRITE: op_dec = OP_WRITE;
			CMD_USED:  op_dec = OP_USED;
			CMD_POLL:  op_dec = OP_POLL;
			CMD_RESET: op_dec = OP_RESET;
			default:   op_dec = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exec_s1 <= 1'b0;
			op_s1   <= OP_NONE;
			done_q  <= 1'b0;
		end else begin
			exec_s1 <= accept;
			if (accept) begin
				op_s1 <= op_dec;
			end
			done_q <= exec_s1;
		end
	end

	assign ctl.load = accept;
	assign ctl.exec = exec_s1;
	assign ctl.op   = op_s1;
	assign done     = done_q;

endmodule

// ----- hw/rtl/vpci_datapath.sv -----
// Datapath of the virtio PCI register block: register file, read mux,
// interrupt pending logic and the registered result.
// Depends on vpci_pkg.
module vpci_datapath #(
	parameter int NUM_QUEUES  = 2,
	parameter int QUEUE_SIZE  = 256,
	parameter int NUM_VECTORS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vpci_pkg::dp_ctl_t  ctl,
	input  vpci_pkg::req_t     req,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output vpci_pkg::rsp_t     rsp
);
	import vpci_pkg::*;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	req_t          req_s1;
	logic [31:0]   host_q;
	logic [31:0]   gfeat_q, gfeat_d;
	logic [7:0]    status_q, status_d;
	logic [QW-1:0] sel_q, sel_d;
	logic          isr_q, isr_d;
	logic [15:0]   cvec_q, cvec_d;
	logic [31:0]   pfn_q  [NUM_QUEUES];
	logic [31:0]   pfn_d  [NUM_QUEUES];
	logic [15:0]   vec_q  [NUM_QUEUES];
	logic [15:0]   vec_d  [NUM_QUEUES];
	logic          pend_q [NUM_QUEUES];
	logic          pend_d [NUM_QUEUES];
	logic [63:0]   rd_val;
	logic          qin_ok;
	logic [QW-1:0] qin_idx;
	logic          bar_ok;
	rsp_t          rsp_d;
	rsp_t          rsp_q;

	assign bar_ok  = (req_s1.bar == 3'd0);
	assign qin_ok  = (32'(req_s1.queue) < 32'(NUM_QUEUES));
	assign qin_idx = QW'(req_s1.queue);

	// Read mux; selected queue is always in range once written
	always_comb begin
		rd_val = ALL_ONES;
		if (bar_ok) begin
			unique case (req_s1.address)
				OFS_HOST_FEAT:      rd_val = 64'(host_q);
				OFS_GUEST_FEATURES: rd_val = 64'(gfeat_q);
				OFS_QUEUE_PFN:      rd_val = 64'(pfn_q[sel_q]);
				OFS_QUEUE_NUM:      rd_val = 64'(QUEUE_SIZE);
				OFS_QUEUE_SEL:      rd_val = 64'(sel_q);
				OFS_STATUS:         rd_val = 64'(status_q);
				OFS_ISR:            rd_val = 64'(isr_q);
				OFS_CONFIG_VECTOR:  rd_val = 64'(cvec_q);
				OFS_QUEUE_VECTOR:   rd_val = 64'(vec_q[sel_q]);
				default:            rd_val = ALL_ONES;
			endcase
		end
	end

	always_comb begin
		gfeat_d  = gfeat_q;
		status_d = status_q;
		sel_d    = sel_q;
		isr_d    = isr_q;
		cvec_d   = cvec_q;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			pfn_d[i]  = pfn_q[i];
			vec_d[i]  = vec_q[i];
			pend_d[i] = pend_q[i];
		end
		rsp_d = '0;

		case (ctl.op)
			OP_READ: begin
				rsp_d.read_data = rd_val;
				if (bar_ok && req_s1.address == OFS_ISR) begin
					isr_d = 1'b0;
				end
			end
			OP_WRITE: begin
				case (req_s1.address)
					OFS_QUEUE_NOTIFY: begin
						if (req_s1.write_data < 32'(NUM_QUEUES)) begin
							rsp_d.notify_valid = 1'b1;
							rsp_d.notify_queue = req_s1.write_data[0];
						end
					end
					OFS_QUEUE_SEL: begin
						if (req_s1.write_data < 32'(NUM_QUEUES)) begin
							sel_d = QW'(req_s1.write_data);
						end
					end
					OFS_QUEUE_PFN:      pfn_d[sel_q] = req_s1.write_data;
					OFS_GUEST_FEATURES: gfeat_d = req_s1.write_data & host_q;
					OFS_STATUS:         status_d = req_s1.write_data[7:0] & STATUS_MASK;
					OFS_CONFIG_VECTOR: begin
						cvec_d = req_s1.write_data[15:0];
						rsp_d.vec_update = 1'b1;
					end
					OFS_QUEUE_VECTOR: begin
						if (req_s1.write_data < 32'(NUM_VECTORS)) begin
							vec_d[sel_q] = req_s1.write_data[15:0];
							rsp_d.vec_update = 1'b1;
						end
					end
					default: ;
				endcase
			end
			OP_USED: begin
				if (qin_ok) begin
					pend_d[qin_idx] = 1'b1;
				end
			end
			OP_POLL: begin
				if (qin_ok) begin
					if (pend_q[qin_idx] && 32'(vec_q[qin_idx]) < 32'(NUM_VECTORS)) begin
						pend_d[qin_idx] = 1'b0;
						if (!req_s1.guest_no_interrupt) begin
							isr_d = 1'b1;
							rsp_d.irq_fire   = 1'b1;
							rsp_d.irq_vector = vec_q[qin_idx];
						end
					end
				end
			end
			OP_RESET: begin
				gfeat_d  = '0;
				status_d = '0;
				sel_d    = '0;
				isr_d    = 1'b0;
				cvec_d   = NO_VECTOR;
				for (int i = 0; i < NUM_QUEUES; i++) begin
					pfn_d[i]  = '0;
					vec_d[i]  = NO_VECTOR;
					pend_d[i] = 1'b0;
				end
			end
			default: ;
		endcase

		// online reflects state after this command
		rsp_d.online = 1'b1;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (pfn_d[i] == 32'd0) begin
				rsp_d.online = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_q   <= '0;
			gfeat_q  <= '0;
			status_q <= '0;
			sel_q    <= '0;
			isr_q    <= 1'b0;
			cvec_q   <= NO_VECTOR;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				pfn_q[i]  <= '0;
				vec_q[i]  <= NO_VECTOR;
				pend_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				host_q <= cfg_wdata;
			end
			if (ctl.exec) begin
				gfeat_q  <= gfeat_d;
				status_q <= status_d;
				sel_q    <= sel_d;
				isr_q    <= isr_d;
				cvec_q   <= cvec_d;
				for (int i = 0; i < NUM_QUEUES; i++) begin
					pfn_q[i]  <= pfn_d[i];
					vec_q[i]  <= vec_d[i];
					pend_q[i] <= pend_d[i];
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_s1 <= req;
		end
		if (ctl.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- hw/rtl/virtio_pci_register_block.sv -----
// Legacy virtio PCI register block, top level.
// Result path: a transferred command is held in req_s1 and exec_s1, and its result
// is registered in rsp_q with done_q; it is on the ports while done is high, where it is taken.
// Throughput: one command per cycle; busy never rises. Receiver cannot stall.
// Reset: arst_n clears all device state and the host feature register; a
// device reset command clears everything but the host features.
//
// Structure: vpci_ctrl takes the start/busy transfer, decodes the command
// code into an operation and issues load/exec strobes; vpci_datapath holds
// the register file, applies one operation per exec cycle and registers
// the result. Commands execute strictly in order, each seeing the state
// left by the one before, so back-to-back commands need no forwarding.
// Depends on vpci_pkg, vpci_ctrl, vpci_datapath.
module virtio_pci_register_block #(
	parameter int NUM_QUEUES  = 2,
	parameter int QUEUE_SIZE  = 256,
	parameter int NUM_VECTORS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	// command channel
	input  logic            start,
	output logic            busy,
	input  vpci_pkg::req_t  request,
	// result channel: one-cycle strobe, no backpressure
	output logic            done,
	output vpci_pkg::rsp_t  response,
	// host feature register
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata
);
	import vpci_pkg::*;

	dp_ctl_t ctl;

	vpci_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.busy    (busy),
		.done    (done),
		.ctl     (ctl)
	);

	// The user must make config writes only while idle, so they never race a command; the block does not enforce this.
	vpci_datapath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_SIZE  (QUEUE_SIZE),
		.NUM_VECTORS (NUM_VECTORS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req       (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (response)
	);

endmodule

// ----- hw/rtl/vpci_checker.sv -----
// Port-level checker for the virtio PCI register block, plus its bind.
// Depends on vpci_pkg and virtio_pci_register_block.
module vpci_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input vpci_pkg::rsp_t  response
);
	import vpci_pkg::*;

	// every transfer yields exactly one result, timed by the exec_s1 and done_q registers
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result missing after command transfer");

	a_done_caused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without command");

	a_vector_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !response.irq_fire) |-> (response.irq_vector == 16'd0))
		else $error("irq_vector nonzero without irq_fire");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(response.vec_update && response.irq_fire))
		else $error("vector update and interrupt in one result");

endmodule

bind virtio_pci_register_block vpci_checker u_vpci_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.response (response)
);

// ----- tb/sv/tb_virtio_pci_register_block.sv -----
// Self-checking testbench for the legacy virtio PCI register block.
// Drives commands, predicts each response in-line and checks every done strobe.
// Depends on vpci_pkg and virtio_pci_register_block.
`timescale 1ns / 100ps

module tb_virtio_pci_register_block;
	import vpci_pkg::*;

	localparam int NUM_QUEUES   = 2;
	localparam int QUEUE_SIZE   = 256;
	localparam int NUM_VECTORS  = 8;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 8;       // idle after the last result is checked
	localparam int LIMIT_CYCLES = 200000;  // ~800 transfers with idle gaps, many times over
	localparam int REQ_W        = $bits(req_t);
	localparam logic [2:0] CMD_MAX = 3'b111;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        done;
	rsp_t        response;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// Shadow copy of the device registers
	logic [31:0] host_feat_m;
	logic [31:0] guest_feat_m;
	logic [7:0]  status_m;
	logic        sel_m;
	logic        isr_m;
	logic [15:0] cfg_vec_m;
	logic [31:0] pfn_m [NUM_QUEUES];
	logic [15:0] qvec_m [NUM_QUEUES];
	logic        pend_m [NUM_QUEUES];

	rsp_t expected_rsp_q [$];
	int   errors;
	int   cmds_sent;
	int   rsps_checked;
	int   irqs_expected;
	int   feature_settings;
	int   cycles;
	bit   idle_enabled;

	virtio_pci_register_block #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_SIZE (QUEUE_SIZE),
		.NUM_VECTORS(NUM_VECTORS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout at %0t with %0d responses outstanding", $time,
				expected_rsp_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Register shadow
	// ---------------------------------------------------------------

	// Device reset: everything except host features
	task automatic clear_device_shadow();
		guest_feat_m = '0;
		status_m     = '0;
		sel_m        = 1'b0;
		isr_m        = 1'b0;
		cfg_vec_m    = NO_VECTOR;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			pfn_m[i]  = '0;
			qvec_m[i] = NO_VECTOR;
			pend_m[i] = 1'b0;
		end
	endtask

	// Applies one command to the shadow and returns the response it should give
	task automatic apply_command(input req_t r, output rsp_t e);
		e = '0;
		case (r.command)
			CMD_READ: begin
				e.read_data = ALL_ONES;
				if (r.bar == '0) begin
					case (r.address)
						OFS_HOST_FEAT:      e.read_data = 64'(host_feat_m);
						OFS_GUEST_FEATURES: e.read_data = 64'(guest_feat_m);
						OFS_QUEUE_PFN:      e.read_data = 64'(pfn_m[sel_m]);
						OFS_QUEUE_NUM:      e.read_data = 64'(QUEUE_SIZE);
						OFS_QUEUE_SEL:      e.read_data = 64'(sel_m);
						OFS_STATUS:         e.read_data = 64'(status_m);
						OFS_ISR: begin
							// read-to-clear
							e.read_data = 64'(isr_m);
							isr_m = 1'b0;
						end
						OFS_CONFIG_VECTOR:  e.read_data = 64'(cfg_vec_m);
						OFS_QUEUE_VECTOR:   e.read_data = 64'(qvec_m[sel_m]);
						default: ;
					endcase
				end
			end
			CMD_WRITE: begin
				// bar is ignored on writes
				case (r.address)
					OFS_QUEUE_NOTIFY: begin
						if (r.write_data < NUM_QUEUES) begin
							e.notify_valid = 1'b1;
							e.notify_queue = r.write_data[0];
						end
					end
					OFS_QUEUE_SEL: begin
						if (r.write_data < NUM_QUEUES)
							sel_m = r.write_data[0];
					end
					OFS_QUEUE_PFN:      pfn_m[sel_m] = r.write_data;
					OFS_GUEST_FEATURES: guest_feat_m = r.write_data & host_feat_m;
					OFS_STATUS:         status_m = r.write_data[7:0] & STATUS_MASK;
					OFS_CONFIG_VECTOR: begin
						cfg_vec_m = r.write_data[15:0];
						e.vec_update = 1'b1;
					end
					OFS_QUEUE_VECTOR: begin
						if (r.write_data < NUM_VECTORS) begin
							qvec_m[sel_m] = r.write_data[15:0];
							e.vec_update = 1'b1;
						end
					end
					default: ;
				endcase
			end
			CMD_USED: pend_m[r.queue] = 1'b1;
			CMD_POLL: begin
				// a queue without a usable vector keeps its pending flag
				if (pend_m[r.queue] && qvec_m[r.queue] < NUM_VECTORS) begin
					pend_m[r.queue] = 1'b0;
					if (!r.guest_no_interrupt) begin
						isr_m        = 1'b1;
						e.irq_fire   = 1'b1;
						e.irq_vector = qvec_m[r.queue];
					end
				end
			end
			CMD_RESET: clear_device_shadow();
			default: ;
		endcase
		e.online = 1'b1;
		for (int i = 0; i < NUM_QUEUES; i++)
			if (pfn_m[i] == '0)
				e.online = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Response checker
	// ---------------------------------------------------------------

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done !== 1'b0) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: unexpected response, expected none actual %h", $time,
					response);
				errors++;
			end else begin
				e = expected_rsp_q.pop_front();
				check_field("read_data", e.read_data, response.read_data);
				check_field("vec_update", 64'(e.vec_update), 64'(response.vec_update));
				check_field("notify_valid", 64'(e.notify_valid), 64'(response.notify_valid));
				check_field("notify_queue", 64'(e.notify_queue), 64'(response.notify_queue));
				check_field("irq_fire", 64'(e.irq_fire), 64'(response.irq_fire));
				check_field("irq_vector", 64'(e.irq_vector), 64'(response.irq_vector));
				check_field("online", 64'(e.online), 64'(response.online));
				rsps_checked++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------

	// start held low while idling, request carries junk meanwhile
	task automatic idle_cycles(input int n);
		logic [63:0] noise;
		repeat (n) begin
			noise = {$urandom, $urandom};
			@(negedge clk);
			start   <= 1'b0;
			request <= req_t'(noise[REQ_W-1:0]);
		end
	endtask

	// One command transfer; the response is predicted at the accepting edge
	task automatic send_cmd(input req_t r);
		rsp_t e;
		if (idle_enabled && $urandom_range(0, 3) == 0)
			idle_cycles($urandom_range(1, 9));
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_command(r, e);
		expected_rsp_q.push_back(e);
		cmds_sent++;
		if (e.irq_fire)
			irqs_expected++;
	endtask

	// host feature register only changes with the block drained
	task automatic write_host_feat(input logic [31:0] value);
		@(negedge clk);
		start <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		host_feat_m = value;
		feature_settings++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t make_cmd(input logic [2:0] cmd, input logic [2:0] bar,
			input logic [7:0] addr, input logic [31:0] wdata, input logic q,
			input logic no_irq);
		req_t r;
		r.command            = cmd;
		r.bar                = bar;
		r.address            = addr;
		r.write_data         = wdata;
		r.queue              = q;
		r.guest_no_interrupt = no_irq;
		return r;
	endfunction

	function automatic logic [7:0] pick_offset();
		case ($urandom_range(0, 9))
			0:       return OFS_HOST_FEAT;
			1:       return OFS_GUEST_FEATURES;
			2:       return OFS_QUEUE_PFN;
			3:       return OFS_QUEUE_NUM;
			4:       return OFS_QUEUE_SEL;
			5:       return OFS_QUEUE_NOTIFY;
			6:       return OFS_STATUS;
			7:       return OFS_ISR;
			8:       return OFS_CONFIG_VECTOR;
			default: return OFS_QUEUE_VECTOR;
		endcase
	endfunction

	// Mostly driver-like traffic on real offsets, some junk commands and offsets
	function automatic req_t random_command();
		req_t        r;
		int unsigned pick;
		r    = make_cmd(CMD_READ, '0, pick_offset(), $urandom, 1'($urandom_range(0, 1)),
			$urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			if ($urandom_range(0, 9) == 0)
				r.bar = 3'($urandom_range(1, 7));
		end else if (pick < 62) begin
			r.command = CMD_WRITE;
			r.bar     = 3'($urandom);
			case (r.address)
				OFS_QUEUE_SEL, OFS_QUEUE_NOTIFY:
					if ($urandom_range(0, 4) != 0)
						r.write_data = $urandom_range(0, NUM_QUEUES - 1);
				OFS_QUEUE_VECTOR:
					case ($urandom_range(0, 5))
						0:       r.write_data = NUM_VECTORS;
						1:       ;
						default: r.write_data = $urandom_range(0, NUM_VECTORS - 1);
					endcase
				OFS_QUEUE_PFN:
					if ($urandom_range(0, 7) == 0)
						r.write_data = '0;
				OFS_CONFIG_VECTOR:
					if ($urandom_range(0, 1) == 0)
						r.write_data = $urandom_range(0, NUM_VECTORS);
				default: ;
			endcase
		end else if (pick < 76) begin
			r.command = CMD_USED;
		end else if (pick < 92) begin
			r.command = CMD_POLL;
		end else if (pick < 95) begin
			r.command = CMD_RESET;
		end else if (pick < 97) begin
			r.command = 3'($urandom_range(CMD_RESET + 1, CMD_MAX));
		end else begin
			r.command = ($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ;
			r.address = 8'($urandom);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Offset decode, bar check, write masks and range checks
	task automatic test_register_decode();
		send_cmd(make_cmd(CMD_READ, '0, OFS_HOST_FEAT, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_READ, '0, OFS_QUEUE_NUM, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_READ, '0, OFS_CONFIG_VECTOR, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_READ, '0, OFS_QUEUE_VECTOR, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_READ, '0, 8'hFF, '0, 1'b0, 1'b0));             // unknown offset
		send_cmd(make_cmd(CMD_READ, 3'h7, OFS_HOST_FEAT, '0, 1'b0, 1'b0));   // nonzero bar
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_GUEST_FEATURES, '1, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_STATUS, '1, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_QUEUE_SEL, NUM_QUEUES, 1'b0, 1'b0)); // ignored
		send_cmd(make_cmd(CMD_WRITE, 3'h7, OFS_QUEUE_SEL, 32'd1, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_QUEUE_PFN, '1, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_QUEUE_NOTIFY, 32'd1, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_QUEUE_NOTIFY, '1, 1'b0, 1'b0));  // no such queue
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_QUEUE_VECTOR, NUM_VECTORS, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_QUEUE_VECTOR, NUM_VECTORS - 1, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_WRITE, '0, OFS_CONFIG_VECTOR, 32'hFFFF_0000, 1'b0, 1'b0));
	endtask

	// Used/poll flow, guest suppression, ISR read-to-clear, odd commands
	task automatic test_interrupt_path();
		send_cmd(make_cmd(CMD_USED, '0, '0, '0, 1'b1, 1'b0));
		send_cmd(make_cmd(CMD_POLL, '0, '0, '0, 1'b1, 1'b1));   // suppressed
		send_cmd(make_cmd(CMD_USED, '0, '0, '0, 1'b1, 1'b0));
		send_cmd(make_cmd(CMD_POLL, '0, '0, '0, 1'b1, 1'b0));   // fires
		send_cmd(make_cmd(CMD_READ, '0, OFS_ISR, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_USED, '0, '0, '0, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_POLL, '0, '0, '0, 1'b0, 1'b0));   // no vector, stays pending
		send_cmd(make_cmd(CMD_MAX, '1, '1, '1, 1'b1, 1'b1));    // unknown command
		send_cmd(make_cmd(CMD_RESET, '0, '0, '0, 1'b0, 1'b0));
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n)
			send_cmd(random_command());
	endtask

	task automatic finish_run();
		@(negedge clk);
		start <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("ran %0d commands under %0d host feature settings", cmds_sent,
			feature_settings);
		$display("checked %0d responses, %0d with an interrupt", rsps_checked,
			irqs_expected);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	endtask

	initial begin
		errors           = 0;
		cmds_sent        = 0;
		rsps_checked     = 0;
		irqs_expected    = 0;
		feature_settings = 0;
		cycles           = 0;
		idle_enabled     = 1'b1;
		arst_n           = 1'b0;
		start            = 1'b0;
		request          = '0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		host_feat_m      = '0;
		clear_device_shadow();
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_host_feat('1);
		test_register_decode();
		test_interrupt_path();

		// Random phases; host features swept between them, idling off in every third
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       write_host_feat('0);
				1:       write_host_feat('1);
				default: write_host_feat($urandom);
			endcase
			idle_enabled = (phase % 3 != 2);
			test_random_traffic(110);
		end

		// Closing stretch back-to-back
		write_host_feat($urandom);
		idle_enabled = 1'b0;
		test_random_traffic(90);

		finish_run();
	end

endmodule

// ----- virtio_pci_register_block.f -----
hw/rtl/vpci_pkg.sv
hw/rtl/vpci_ctrl.sv
hw/rtl/vpci_datapath.sv
hw/rtl/virtio_pci_register_block.sv
hw/rtl/vpci_checker.sv
tb/sv/tb_virtio_pci_register_block.sv
